/* design/vfd_multiplex_scan_serializer_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the tube display scan serialiser
// Clocked property checks with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef VFD_MULTIPLEX_SCAN_SERIALIZER_ASSERT_SVH
`define VFD_MULTIPLEX_SCAN_SERIALIZER_ASSERT_SVH

// check a property while out of reset
`define VMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property at every edge, reset included
`define VMS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/vms_pkg.sv */
// ----------------------------------------------------------------------------
// vms_pkg
// Shared types and constants for the tube display scan serialiser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vms_pkg;

  localparam int TUBE_COUNT_DEF = 6;
  localparam int SHIFT_BITS_DEF = 20;

  localparam int KIND_W  = 2;
  localparam int SLOT_W  = 4;
  localparam int PAT_W   = 16;
  localparam int COMMA_W = 2;
  localparam int GRID_W  = 4;
  localparam int ENTRY_W = PAT_W + COMMA_W;
  localparam int WORD_W  = 32;

  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SNAP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

  localparam logic [1:0] LOW_ONES = 2'b11;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [GRID_W-1:0] grid_index;
    logic              grid_on;
    logic              dot_on;
  } scan_cmd_t;

  typedef struct packed {
    logic can_push;
    logic has_item;
  } q_stat_t;

endpackage

/* design/vms_front.sv */
// ----------------------------------------------------------------------------
// vms_front
// Accepts items, keeps the tube tables and scan position, and turns each
// scan tick into a command for the serialiser queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vms_front import vms_pkg::*; #(
  parameter int TUBE_COUNT = TUBE_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [SLOT_W-1:0]   in_slot,
  input  logic [PAT_W-1:0]    in_segment_pattern,
  input  logic [COMMA_W-1:0]  in_comma_bits,
  input  logic                in_blink_dots,
  input  logic                in_fading,
  input  logic                in_show_seconds,
  input  q_stat_t             q_stat,
  output logic                q_push,
  output scan_cmd_t           q_data
);

  localparam int IDX_W = (TUBE_COUNT > 1) ? $clog2(TUBE_COUNT) : 1;

  logic [ENTRY_W-1:0] next_r  [TUBE_COUNT];
  logic [ENTRY_W-1:0] shown_r [TUBE_COUNT];
  logic [GRID_W-1:0]  pos_r, pos_nxt;
  logic               blink_r;
  logic               accept;
  logic               slot_ok;
  logic               last_two;
  logic [ENTRY_W-1:0] entry;

  assign in_ready = (in_kind != KIND_TICK) || q_stat.can_push;
  assign accept   = in_valid && in_ready;
  assign slot_ok  = {1'b0, in_slot} < (SLOT_W + 1)'(TUBE_COUNT);

  always_comb begin
    if (pos_r == GRID_W'(TUBE_COUNT - 1)) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  assign entry    = in_fading ? shown_r[pos_nxt[IDX_W-1:0]] : next_r[pos_nxt[IDX_W-1:0]];
  assign last_two = (pos_nxt == GRID_W'(TUBE_COUNT - 2)) ||
                    (pos_nxt == GRID_W'(TUBE_COUNT - 1));

  assign q_push          = accept && (in_kind == KIND_TICK);
  assign q_data.word     = WORD_W'({entry, LOW_ONES});
  assign q_data.grid_index = pos_nxt;
  assign q_data.grid_on  = in_show_seconds || !last_two;
  assign q_data.dot_on   = (pos_nxt == '0) && blink_r && in_show_seconds;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      blink_r <= 1'b0;
      for (int i = 0; i < TUBE_COUNT; i++) begin
        next_r[i]  <= '0;
        shown_r[i] <= '0;
      end
    end else if (accept) begin
      case (in_kind)
        KIND_LOAD: begin
          if (slot_ok) begin
            next_r[in_slot[IDX_W-1:0]] <= {in_segment_pattern, in_comma_bits};
          end
        end
        KIND_SNAP: begin
          blink_r <= in_blink_dots;
          for (int i = 0; i < TUBE_COUNT; i++) begin
            shown_r[i] <= next_r[i];
          end
        end
        KIND_TICK: begin
          pos_r <= pos_nxt;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* design/vms_queue.sv */
// ----------------------------------------------------------------------------
// vms_queue
// Two-entry command queue between the front end and the serialiser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vms_queue import vms_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  scan_cmd_t push_data,
  input  logic      pop,
  output scan_cmd_t head,
  output q_stat_t   stat
);

  scan_cmd_t  mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign head          = mem_r[rd_ptr_r];
  assign stat.can_push = (count_r != 2'd2);
  assign stat.has_item = (count_r != 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* design/vms_back.sv */
// ----------------------------------------------------------------------------
// vms_back
// Serialises each queued command LSB first, then issues the latch strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vms_back import vms_pkg::*; #(
  parameter int SHIFT_BITS = SHIFT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  q_stat_t           q_stat,
  input  scan_cmd_t         q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_serial_bit,
  output logic              out_strobe_res,
  output logic [GRID_W-1:0] out_grid_index,
  output logic              out_grid_on,
  output logic              out_dot_on,
  output logic              out_last
);

  localparam int CNT_W = $clog2(SHIFT_BITS + 1);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_SHIFT = 2'b10
  } back_state_t;

  back_state_t       state_r, state_nxt;
  scan_cmd_t         cmd_r, cmd_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              valid_r, valid_nxt;
  logic              bit_r, bit_nxt;
  logic              stb_r, stb_nxt;
  logic [GRID_W-1:0] grid_r, grid_nxt;
  logic              gon_r, gon_nxt;
  logic              dot_r, dot_nxt;
  logic              advance;
  logic              have;
  scan_cmd_t         cur;
  logic [CNT_W-1:0]  cur_cnt;
  logic [WORD_W-1:0] shifted;

  assign advance = !valid_r || out_ready;
  assign have    = (state_r == ST_SHIFT) || q_stat.has_item;
  assign cur     = (state_r == ST_SHIFT) ? cmd_r : q_head;
  assign cur_cnt = (state_r == ST_SHIFT) ? cnt_r : '0;
  assign shifted = cur.word >> cur_cnt;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    cnt_nxt   = cnt_r;
    valid_nxt = valid_r;
    bit_nxt   = bit_r;
    stb_nxt   = stb_r;
    grid_nxt  = grid_r;
    gon_nxt   = gon_r;
    dot_nxt   = dot_r;
    q_pop     = 1'b0;
    if (advance) begin
      valid_nxt = have;
      if (have) begin
        if (cur_cnt < CNT_W'(SHIFT_BITS)) begin
          bit_nxt  = shifted[0];
          stb_nxt  = 1'b0;
          grid_nxt = '0;
          gon_nxt  = 1'b0;
          dot_nxt  = 1'b0;
          cnt_nxt  = cur_cnt + 1'b1;
          if (state_r == ST_IDLE) begin
            q_pop     = 1'b1;
            cmd_nxt   = q_head;
            state_nxt = ST_SHIFT;
          end
        end else begin
          bit_nxt   = 1'b0;
          stb_nxt   = 1'b1;
          grid_nxt  = cur.grid_index;
          gon_nxt   = cur.grid_on;
          dot_nxt   = cur.dot_on;
          state_nxt = ST_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    bit_r  <= bit_nxt;
    stb_r  <= stb_nxt;
    grid_r <= grid_nxt;
    gon_r  <= gon_nxt;
    dot_r  <= dot_nxt;
  end

  assign out_valid      = valid_r;
  assign out_serial_bit = bit_r;
  assign out_strobe_res = stb_r;
  assign out_grid_index = grid_r;
  assign out_grid_on    = gon_r;
  assign out_dot_on     = dot_r;
  assign out_last       = stb_r;

endmodule

/* design/vfd_multiplex_scan_serializer.sv */
// ----------------------------------------------------------------------------
// vfd_multiplex_scan_serializer
// Multiplexed tube display scanner with a serial shift-register driver.
//
//   Channel   Direction  Handshake           Payload
//   in_       input      in_valid/in_ready   kind, slot, pattern, commas, flags
//   out_      output     out_valid/out_ready bit or strobe with grid and dot
//
// Load and snapshot items give no result.
// A scan tick gives SHIFT_BITS bit items and one strobe item, one per cycle
// while out_ready does not hold the output back.
// Ticks queue two deep, so the front accepts ticks while the serialiser runs until the queue is full.
// Synchronous active-low reset clears both tables, position and blink flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "vfd_multiplex_scan_serializer_assert.svh"

module vfd_multiplex_scan_serializer import vms_pkg::*; #(
  parameter int TUBE_COUNT = TUBE_COUNT_DEF,
  parameter int SHIFT_BITS = SHIFT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [SLOT_W-1:0]  in_slot,
  input  logic [PAT_W-1:0]   in_segment_pattern,
  input  logic [COMMA_W-1:0] in_comma_bits,
  input  logic               in_blink_dots,
  input  logic               in_fading,
  input  logic               in_show_seconds,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_serial_bit,
  output logic               out_strobe_res,
  output logic [GRID_W-1:0]  out_grid_index,
  output logic               out_grid_on,
  output logic               out_dot_on,
  output logic               out_last
);

  q_stat_t   q_stat;
  logic      q_push;
  logic      q_pop;
  scan_cmd_t q_data;
  scan_cmd_t q_head;
  logic      grid_ok;
  logic      bit_quiet;

  vms_front #(
    .TUBE_COUNT(TUBE_COUNT)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_slot           (in_slot),
    .in_segment_pattern(in_segment_pattern),
    .in_comma_bits     (in_comma_bits),
    .in_blink_dots     (in_blink_dots),
    .in_fading         (in_fading),
    .in_show_seconds   (in_show_seconds),
    .q_stat            (q_stat),
    .q_push            (q_push),
    .q_data            (q_data)
  );

  vms_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_data),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  vms_back #(
    .SHIFT_BITS(SHIFT_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_serial_bit(out_serial_bit),
    .out_strobe_res(out_strobe_res),
    .out_grid_index(out_grid_index),
    .out_grid_on   (out_grid_on),
    .out_dot_on    (out_dot_on),
    .out_last      (out_last)
  );

  assign grid_ok   = ({1'b0, out_grid_index} < (GRID_W + 1)'(TUBE_COUNT));
  assign bit_quiet = !out_grid_on && !out_dot_on && !out_last;

  `VMS_ASSERT(a_no_overflow, q_push |-> q_stat.can_push, "tick queue overflow")
  `VMS_ASSERT(a_no_underflow, q_pop |-> q_stat.has_item, "tick queue underflow")
  `VMS_ASSERT(a_grid_range, out_valid && out_last |-> grid_ok, "grid index beyond tube count")
  `VMS_ASSERT(a_bit_item_quiet, out_valid && !out_strobe_res |-> bit_quiet, "control on bit item")
  `VMS_ASSERT_ALWAYS(a_reset_idle, $past(!rst_n) |-> !out_valid, "result valid after reset")

endmodule
